// ===== rtl/core/fsba_pkg.sv =====
// ----------------------------------------------------------------------------
// fsba_pkg
// Shared constants, codes and controller/datapath types of the fit-strategy
// block allocator.
// ----------------------------------------------------------------------------
package fsba_pkg;

   localparam int NBLOCKS   = 16;
   localparam int SIZE_BITS = 24;

   localparam int IDX_W = (NBLOCKS > 1) ? $clog2(NBLOCKS) : 1;
   localparam int CNT_W = $clog2(NBLOCKS + 1);

   // fixed port widths
   localparam int AMT_W      = 24;
   localparam int SLOT_W     = 4;
   localparam int BIDX_W     = 4;
   localparam int STRAT_W    = 2;
   localparam int BCNT_W     = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   localparam logic [BCNT_W-1:0] BCNT_RESET = BCNT_W'(16);

   localparam logic [CSR_IDX_W-1:0] REG_STRATEGY    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_COUNT = 1'b1;

   localparam logic FUNC_LOAD    = 1'b0;
   localparam logic FUNC_REQUEST = 1'b1;

   typedef enum logic [STRAT_W-1:0] {
      STRAT_FIRST = 2'd0,
      STRAT_BEST  = 2'd1,
      STRAT_WORST = 2'd2,
      STRAT_NEXT  = 2'd3
   } strategy_type;

   typedef struct packed {
      logic capture;   // transaction accepted this cycle
      logic load_wr;   // write a loaded block size
      logic scan;      // walk the size table
      logic finish;    // commit placement and emit response
   } cmd_type;

   typedef struct packed {
      logic scan_done;
   } status_type;

endpackage

// ===== rtl/core/fsba_ctrl.sv =====
// ----------------------------------------------------------------------------
// fsba_ctrl
// Sequencer of the allocator: load, table scan, commit.
// ----------------------------------------------------------------------------
module fsba_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_func,
   input  fsba_pkg::status_type status,
   output fsba_pkg::cmd_type    cmd,
   output logic                busy
);
   import fsba_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;
   logic      accept;

   assign accept = start && !busy_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_func == FUNC_REQUEST) ? ST_SCAN : ST_LOAD;
            end
         end
         ST_LOAD:   state_in = ST_IDLE;
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   always_comb begin
      cmd.capture = accept;
      cmd.load_wr = (state_ff == ST_LOAD);
      cmd.scan    = (state_ff == ST_SCAN);
      cmd.finish  = (state_ff == ST_FINISH);
   end

   assign busy = busy_ff;

endmodule

// ===== rtl/core/fsba_dp.sv =====
// ----------------------------------------------------------------------------
// fsba_dp
// Size table, config registers, scan pointer, fit compare and response regs.
// ----------------------------------------------------------------------------
module fsba_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  fsba_pkg::cmd_type               cmd,
   output fsba_pkg::status_type            status,
   input  logic [fsba_pkg::SLOT_W-1:0]     req_block_slot,
   input  logic [fsba_pkg::AMT_W-1:0]      req_amount,
   input  logic                            csr_we,
   input  logic [fsba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fsba_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                            rsp_valid,
   output logic                            rsp_placed,
   output logic [fsba_pkg::BIDX_W-1:0]     rsp_block_index
);
   import fsba_pkg::*;

   logic [SIZE_BITS-1:0] mem [NBLOCKS];

   strategy_type         strat_ff;
   logic [BCNT_W-1:0]    bcnt_ff;
   logic [IDX_W-1:0]     next_start_ff;

   logic [SIZE_BITS-1:0] amt_ff;
   logic [IDX_W-1:0]     slot_ff;
   logic                 slot_ok_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [CNT_W-1:0]     j_ff;
   logic [IDX_W-1:0]     k_ff;
   logic [SIZE_BITS-1:0] rd_ff;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic                 rd_vld_ff;
   logic                 found_ff;
   logic [IDX_W-1:0]     best_idx_ff;
   logic [SIZE_BITS-1:0] best_val_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_placed_ff;
   logic [BIDX_W-1:0]    rsp_block_index_ff;

   logic [CNT_W-1:0]     live_cnt;
   logic [IDX_W-1:0]     scan_first;
   logic                 issue;
   logic [CNT_W-1:0]     k_inc;
   logic [IDX_W-1:0]     k_in;
   logic                 fits;
   logic                 take;
   logic [CNT_W-1:0]     pick_inc;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [SIZE_BITS-1:0] wr_data;

   assign live_cnt   = (32'(bcnt_ff) > NBLOCKS) ? CNT_W'(NBLOCKS) : CNT_W'(bcnt_ff);
   // only next fit starts past block 0; a stale pointer restarts at block 0
   assign scan_first = ((strat_ff == STRAT_NEXT) && (CNT_W'(next_start_ff) < live_cnt)) ?
                       next_start_ff : '0;

   assign issue = cmd.scan && (j_ff != cnt_ff);
   assign k_inc = CNT_W'(k_ff) + CNT_W'(1);
   assign k_in  = (k_inc >= cnt_ff) ? '0 : IDX_W'(k_inc);

   assign fits = (rd_ff >= amt_ff);
   // first and next fit keep the first hit; ties keep the lower index
   always_comb begin
      take = 1'b0;
      if (rd_vld_ff && fits) begin
         if (!found_ff) begin
            take = 1'b1;
         end else begin
            case (strat_ff)
               STRAT_BEST:  take = (rd_ff < best_val_ff);
               STRAT_WORST: take = (rd_ff > best_val_ff);
               default:     take = 1'b0;
            endcase
         end
      end
   end

   assign status.scan_done = (j_ff == cnt_ff) && !rd_vld_ff;

   assign pick_inc = CNT_W'(best_idx_ff) + CNT_W'(1);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = slot_ff;
      wr_data = amt_ff;
      if (cmd.load_wr) begin
         wr_en = slot_ok_ff;
      end else if (cmd.finish) begin
         wr_en   = found_ff;
         wr_addr = best_idx_ff;
         wr_data = best_val_ff - amt_ff;
      end
   end

   // size table
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (issue) begin
         rd_ff <= mem[k_ff];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         strat_ff      <= STRAT_FIRST;
         bcnt_ff       <= BCNT_RESET;
         next_start_ff <= '0;
         rd_vld_ff     <= 1'b0;
         found_ff      <= 1'b0;
         j_ff          <= '0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_STRATEGY:    strat_ff <= strategy_type'(csr_wdata[STRAT_W-1:0]);
               REG_BLOCK_COUNT: bcnt_ff  <= csr_wdata[BCNT_W-1:0];
               default:         ;
            endcase
         end
         rd_vld_ff    <= issue;
         rsp_valid_ff <= cmd.finish;
         if (cmd.capture) begin
            j_ff     <= '0;
            cnt_ff   <= live_cnt;
            found_ff <= 1'b0;
         end else begin
            if (issue) begin
               j_ff <= j_ff + CNT_W'(1);
            end
            if (take) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.load_wr && slot_ok_ff) begin
            next_start_ff <= '0;
         end else if (cmd.finish && found_ff && (strat_ff == STRAT_NEXT)) begin
            next_start_ff <= (pick_inc < cnt_ff) ? IDX_W'(pick_inc) : '0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         amt_ff     <= SIZE_BITS'(req_amount);
         slot_ff    <= IDX_W'(req_block_slot);
         slot_ok_ff <= (32'(req_block_slot) < NBLOCKS);
         k_ff       <= scan_first;
      end else if (issue) begin
         k_ff <= k_in;
      end
      if (issue) begin
         rd_idx_ff <= k_ff;
      end
      if (take) begin
         best_idx_ff <= rd_idx_ff;
         best_val_ff <= rd_ff;
      end
      if (cmd.finish) begin
         rsp_placed_ff      <= found_ff;
         rsp_block_index_ff <= found_ff ? BIDX_W'(best_idx_ff) : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_placed      = rsp_placed_ff;
   assign rsp_block_index = rsp_block_index_ff;

   a_unplaced_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_placed_ff |-> rsp_block_index_ff == '0)
      else $error("unplaced response carries a nonzero block index");

   a_read_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> $past(cmd.scan))
      else $error("table read outside of a scan");

   a_scan_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.scan |-> j_ff <= cnt_ff)
      else $error("scan counter ran past the block count");

   a_pick_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && found_ff |-> CNT_W'(best_idx_ff) < cnt_ff)
      else $error("chosen block outside the blocks in use");

endmodule

// ===== rtl/core/fit_strategy_block_allocator.sv =====
// Load transaction: busy after acceptance, no response.
// Request transaction: the size table is scanned over the blocks in use, then the placement is
// committed and rsp_valid strobes; the table is read one entry per cycle.
// A new transaction is accepted only while busy is low, after the previous one has finished.
// Synchronous reset: strategy first fit, block count 16, next-fit pointer 0, idle.
// Block sizes are not cleared by reset; every block in use must be loaded first.
// ----------------------------------------------------------------------------
// fit_strategy_block_allocator
// First/best/worst/next fit allocator over a table of free block sizes.
// ----------------------------------------------------------------------------
module fit_strategy_block_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_func,
   input  logic [fsba_pkg::SLOT_W-1:0]     req_block_slot,
   input  logic [fsba_pkg::AMT_W-1:0]      req_amount,
   output logic                            rsp_valid,
   output logic                            rsp_placed,
   output logic [fsba_pkg::BIDX_W-1:0]     rsp_block_index,
   input  logic                            csr_we,
   input  logic [fsba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fsba_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import fsba_pkg::*;

   cmd_type    cmd;
   status_type status;

   fsba_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   fsba_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_block_slot  (req_block_slot),
      .req_amount      (req_amount),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_placed      (rsp_placed),
      .rsp_block_index (rsp_block_index)
   );

endmodule

// ===== verif/fit_strategy_block_allocator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fit_strategy_block_allocator_test
// Self-checking bench for the fit-strategy allocator: loads every block, runs
// directed placements under each strategy and block count corner, then random
// phases of loads and requests with random idle gaps. A scoreboard model of
// the size table predicts every placement transaction.
// ----------------------------------------------------------------------------
module fit_strategy_block_allocator_test;
   import fsba_pkg::*;

   localparam int SETTLE_CYCLES = NBLOCKS + 8;

   typedef enum logic [1:0] {OP_ITEM, OP_CSR, OP_DRAIN} op_kind_type;

   typedef struct {
      op_kind_type             kind;
      logic                    func;
      logic [SLOT_W-1:0]       slot;
      logic [AMT_W-1:0]        amount;
      logic [CSR_IDX_W-1:0]    csr_idx;
      logic [CSR_DATA_W-1:0]   csr_data;
      int unsigned             gap;
   } stim_op_type;

   typedef struct packed {
      logic              placed;
      logic [BIDX_W-1:0] index;
   } placement_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_func = FUNC_LOAD;
   logic [SLOT_W-1:0]     req_block_slot = '0;
   logic [AMT_W-1:0]      req_amount = '0;
   logic                  rsp_valid;
   logic                  rsp_placed;
   logic [BIDX_W-1:0]     rsp_block_index;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = REG_STRATEGY;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // scoreboard copy of the allocator state
   logic [SIZE_BITS-1:0]  free_size [NBLOCKS];
   logic [IDX_W-1:0]      next_ptr = '0;
   strategy_type          strat_cfg = STRAT_FIRST;
   logic [BCNT_W-1:0]     count_cfg = BCNT_RESET;

   stim_op_type           pending_ops[$];
   placement_type         placements_due[$];
   int unsigned           gap_mode = 0;
   int unsigned           idle_left = 0;
   int unsigned           settle = 0;
   int                    failures = 0;

   fit_strategy_block_allocator dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_block_slot  (req_block_slot),
      .req_amount      (req_amount),
      .rsp_valid       (rsp_valid),
      .rsp_placed      (rsp_placed),
      .rsp_block_index (rsp_block_index),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Picks a block for a request and commits it to the scoreboard table.
   function automatic placement_type allocate(logic [AMT_W-1:0] amount);
      int            live;
      int            first;
      int            j;
      int            k;
      int            pick;
      bit            found;
      logic [SIZE_BITS-1:0] want;
      placement_type res;
      live  = (count_cfg > NBLOCKS) ? NBLOCKS : int'(count_cfg);
      want  = amount[SIZE_BITS-1:0];
      found = 1'b0;
      pick  = 0;
      if (strat_cfg == STRAT_NEXT) begin
         first = (int'(next_ptr) < live) ? int'(next_ptr) : 0;
         for (j = 0; j < live && !found; j++) begin
            k = (first + j) % live;
            if (free_size[k] >= want) begin
               found = 1'b1;
               pick  = k;
            end
         end
      end else begin
         for (j = 0; j < live && !(found && strat_cfg == STRAT_FIRST); j++) begin
            if (free_size[j] >= want) begin
               if (!found) begin
                  found = 1'b1;
                  pick  = j;
               end else if (strat_cfg == STRAT_BEST && free_size[j] < free_size[pick]) begin
                  pick = j;
               end else if (strat_cfg == STRAT_WORST && free_size[j] > free_size[pick]) begin
                  pick = j;
               end
            end
         end
      end
      res = '0;
      if (found) begin
         free_size[pick] = free_size[pick] - want;
         if (strat_cfg == STRAT_NEXT)
            next_ptr = (pick + 1 < live) ? IDX_W'(pick + 1) : '0;
         res.placed = 1'b1;
         res.index  = BIDX_W'(pick);
      end
      return res;
   endfunction

   function automatic logic [AMT_W-1:0] pick_amount(bit for_load);
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r < 4) return AMT_W'($urandom);
      return AMT_W'($urandom_range(0, for_load ? 8191 : 3071));
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (gap_mode == 0) return 0;
      r = $urandom_range(0, 15);
      if (r < 9) return 0;
      if (r < 14) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic push_op(op_kind_type kind, logic func, logic [SLOT_W-1:0] slot,
                          logic [AMT_W-1:0] amount, logic [CSR_IDX_W-1:0] idx,
                          logic [CSR_DATA_W-1:0] data);
      stim_op_type op;
      op.kind     = kind;
      op.func     = func;
      op.slot     = slot;
      op.amount   = amount;
      op.csr_idx  = idx;
      op.csr_data = data;
      op.gap      = (kind == OP_ITEM) ? pick_gap() : 0;
      pending_ops.push_back(op);
   endtask

   // Driver: one transaction or register write per item or register op, in order; drain ops wait.
   always @(posedge clock) begin : drive_ops
      logic        hold;
      logic        write_en;
      stim_op_type head;
      hold     = 1'b0;
      write_en = 1'b0;
      if (reset) begin
         idle_left = 0;
         settle    = 0;
      end else begin
         if (start && !busy) begin
            head = pending_ops.pop_front();
            if (head.func == FUNC_LOAD) begin
               free_size[head.slot] = head.amount[SIZE_BITS-1:0];
               next_ptr = '0;
            end else begin
               placements_due.push_back(allocate(head.amount));
            end
            if (pending_ops.size() != 0) idle_left = pending_ops[0].gap;
         end else if (start) begin
            hold = 1'b1;
         end
         if (!hold && pending_ops.size() != 0) begin
            if (idle_left != 0) begin
               idle_left--;
            end else begin
               head = pending_ops[0];
               case (head.kind)
                  OP_ITEM: begin
                     hold = 1'b1;
                     req_func       <= head.func;
                     req_block_slot <= head.slot;
                     req_amount     <= head.amount;
                  end
                  OP_CSR: begin
                     write_en = 1'b1;
                     csr_index <= head.csr_idx;
                     csr_wdata <= head.csr_data;
                     if (head.csr_idx == REG_STRATEGY)
                        strat_cfg = strategy_type'(head.csr_data[STRAT_W-1:0]);
                     else
                        count_cfg = head.csr_data;
                     void'(pending_ops.pop_front());
                     if (pending_ops.size() != 0) idle_left = pending_ops[0].gap;
                  end
                  default: begin
                     // quiet point: all placements back, block idle, then a pause
                     if (placements_due.size() == 0 && !busy) begin
                        if (settle >= SETTLE_CYCLES) begin
                           settle = 0;
                           void'(pending_ops.pop_front());
                           if (pending_ops.size() != 0) idle_left = pending_ops[0].gap;
                        end else begin
                           settle++;
                        end
                     end else begin
                        settle = 0;
                     end
                  end
               endcase
            end
         end
      end
      start  <= hold;
      csr_we <= write_en;
   end

   always @(posedge clock) begin : check_placements
      placement_type due;
      if (!reset && rsp_valid) begin
         if (placements_due.size() == 0) begin
            $error("unexpected result transaction: placed %0d index %0d",
                   rsp_placed, rsp_block_index);
            failures++;
         end else begin
            due = placements_due.pop_front();
            if (rsp_placed !== due.placed) begin
               $error("placed: expected %0d, got %0d", due.placed, rsp_placed);
               failures++;
            end
            if (rsp_block_index !== due.index) begin
               $error("block_index: expected %0d, got %0d", due.index, rsp_block_index);
               failures++;
            end
         end
      end
   end

   initial begin
      int           phase;
      int           n;
      int           s;
      int unsigned  r;
      int unsigned  load_pct;
      logic [1:0]   strat_val;
      logic [BCNT_W-1:0] count_val;

      // Directed: load every block, then strategy and block count corners.
      gap_mode = 0;
      for (s = 0; s < NBLOCKS; s++)
         push_op(OP_ITEM, FUNC_LOAD, SLOT_W'(s),
                 (s == 3) ? '1 : AMT_W'((s * 37) % 200), REG_STRATEGY, '0);
      push_op(OP_ITEM, FUNC_REQUEST, '0, '0, REG_STRATEGY, '0);
      push_op(OP_ITEM, FUNC_REQUEST, '1, '1, REG_STRATEGY, '0);
      push_op(OP_ITEM, FUNC_REQUEST, '0, '1, REG_STRATEGY, '0);
      push_op(OP_DRAIN, FUNC_LOAD, '0, '0, REG_STRATEGY, '0);
      push_op(OP_CSR, FUNC_LOAD, '0, '0, REG_STRATEGY, CSR_DATA_W'(STRAT_BEST));
      push_op(OP_ITEM, FUNC_REQUEST, '0, 24'd50, REG_STRATEGY, '0);
      push_op(OP_DRAIN, FUNC_LOAD, '0, '0, REG_STRATEGY, '0);
      push_op(OP_CSR, FUNC_LOAD, '0, '0, REG_STRATEGY, CSR_DATA_W'(STRAT_WORST));
      push_op(OP_ITEM, FUNC_REQUEST, '0, 24'd10, REG_STRATEGY, '0);
      push_op(OP_DRAIN, FUNC_LOAD, '0, '0, REG_STRATEGY, '0);
      push_op(OP_CSR, FUNC_LOAD, '0, '0, REG_STRATEGY, CSR_DATA_W'(STRAT_NEXT));
      push_op(OP_CSR, FUNC_LOAD, '0, '0, REG_BLOCK_COUNT, 5'd16);
      // next fit runs off the top block and wraps to block 0
      push_op(OP_ITEM, FUNC_REQUEST, '0, 24'd150, REG_STRATEGY, '0);
      push_op(OP_ITEM, FUNC_REQUEST, '0, 24'd150, REG_STRATEGY, '0);
      push_op(OP_ITEM, FUNC_REQUEST, '0, 24'd160, REG_STRATEGY, '0);
      // shrink the table under a stale next pointer
      push_op(OP_DRAIN, FUNC_LOAD, '0, '0, REG_STRATEGY, '0);
      push_op(OP_CSR, FUNC_LOAD, '0, '0, REG_BLOCK_COUNT, 5'd4);
      push_op(OP_ITEM, FUNC_REQUEST, '0, 24'd30, REG_STRATEGY, '0);
      push_op(OP_DRAIN, FUNC_LOAD, '0, '0, REG_STRATEGY, '0);
      push_op(OP_CSR, FUNC_LOAD, '0, '0, REG_BLOCK_COUNT, 5'd0);
      push_op(OP_ITEM, FUNC_REQUEST, '0, '0, REG_STRATEGY, '0);
      push_op(OP_DRAIN, FUNC_LOAD, '0, '0, REG_STRATEGY, '0);
      push_op(OP_CSR, FUNC_LOAD, '0, '0, REG_BLOCK_COUNT, 5'd31);
      push_op(OP_ITEM, FUNC_REQUEST, '0, '0, REG_STRATEGY, '0);

      // Random phases: new settings at each quiet point.
      for (phase = 0; phase < 34; phase++) begin
         push_op(OP_DRAIN, FUNC_LOAD, '0, '0, REG_STRATEGY, '0);
         strat_val = 2'($urandom_range(0, 3));
         push_op(OP_CSR, FUNC_LOAD, '0, '0, REG_STRATEGY,
                 {3'($urandom_range(0, 7)), strat_val});
         r = $urandom_range(0, 19);
         if (r == 0)      count_val = '0;
         else if (r == 1) count_val = BCNT_W'($urandom_range(17, 31));
         else if (r == 2) count_val = 5'd1;
         else if (r < 6)  count_val = 5'd16;
         else             count_val = BCNT_W'($urandom_range(1, 16));
         push_op(OP_CSR, FUNC_LOAD, '0, '0, REG_BLOCK_COUNT, count_val);
         gap_mode = $urandom_range(0, 3);
         // loads rewind the next-fit pointer, so keep them rarer there
         load_pct = (strategy_type'(strat_val) == STRAT_NEXT) ? 10 : 25;
         for (n = $urandom_range(15, 35); n > 0; n--) begin
            if ($urandom_range(0, 99) < load_pct)
               push_op(OP_ITEM, FUNC_LOAD, SLOT_W'($urandom), pick_amount(1'b1),
                       REG_STRATEGY, '0);
            else
               push_op(OP_ITEM, FUNC_REQUEST, SLOT_W'($urandom), pick_amount(1'b0),
                       REG_STRATEGY, '0);
            if ($urandom_range(0, 29) == 0)
               push_op(OP_DRAIN, FUNC_LOAD, '0, '0, REG_STRATEGY, '0);
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_ops.size() != 0 || placements_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
